// File: hw/rtl/oriented_box_overlap_test_unit_macros.svh
`ifndef ORIENTED_BOX_OVERLAP_TEST_UNIT_MACROS_SVH
`define ORIENTED_BOX_OVERLAP_TEST_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define OBOT_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OBOT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define OBOT_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define OBOT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: hw/rtl/obot_pkg.sv
package obot_pkg;

  localparam int FIELD_W  = 16;
  localparam int NUM_CRN  = 4;
  localparam int NUM_PTS  = 2 * NUM_CRN;
  localparam int NUM_AXES = 4;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TEST = 1'b1
  } cmd_t;

  // per-stage load enables for the lane pipeline
  typedef struct packed {
    logic en_b;
    logic en_c;
    logic en_d;
    logic en_e;
  } ctl_t;

endpackage

// File: hw/rtl/obot_lane.sv
module obot_lane #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  obot_pkg::ctl_t               ctl,
  input  logic signed [COORD_BITS:0]   axis_x,
  input  logic signed [COORD_BITS:0]   axis_y,
  input  logic signed [COORD_BITS-1:0] pt_x [obot_pkg::NUM_PTS],
  input  logic signed [COORD_BITS-1:0] pt_y [obot_pkg::NUM_PTS],
  output logic                         hit
);

  localparam int PW = 2 * COORD_BITS + 1;
  localparam int DW = 2 * COORD_BITS + 2;
  localparam int NP = obot_pkg::NUM_PTS;
  localparam int NC = obot_pkg::NUM_CRN;

  logic signed [PW-1:0] prod_x_r [NP];
  logic signed [PW-1:0] prod_y_r [NP];
  logic signed [DW-1:0] dot_r    [NP];
  logic signed [DW-1:0] amin_r, amax_r, bmin_r, bmax_r;
  logic signed [DW-1:0] amin_nxt, amax_nxt, bmin_nxt, bmax_nxt;
  logic                 hit_r, hit_nxt;

  // stage B: one product per coordinate
  always_ff @(posedge clk) begin
    if (ctl.en_b) begin
      for (int k = 0; k < NP; k++) begin
        prod_x_r[k] <= PW'(pt_x[k]) * PW'(axis_x);
        prod_y_r[k] <= PW'(pt_y[k]) * PW'(axis_y);
      end
    end
  end

  // stage C: projections
  always_ff @(posedge clk) begin
    if (ctl.en_c) begin
      for (int k = 0; k < NP; k++) begin
        dot_r[k] <= DW'(prod_x_r[k]) + DW'(prod_y_r[k]);
      end
    end
  end

  // stage D: extent of each box on the axis; reference is points 0..3
  always_comb begin
    amin_nxt = dot_r[0];
    amax_nxt = dot_r[0];
    bmin_nxt = dot_r[NC];
    bmax_nxt = dot_r[NC];
    for (int k = 1; k < NC; k++) begin
      if (dot_r[k] < amin_nxt) amin_nxt = dot_r[k];
      if (dot_r[k] > amax_nxt) amax_nxt = dot_r[k];
      if (dot_r[NC+k] < bmin_nxt) bmin_nxt = dot_r[NC+k];
      if (dot_r[NC+k] > bmax_nxt) bmax_nxt = dot_r[NC+k];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_d) begin
      amin_r <= amin_nxt;
      amax_r <= amax_nxt;
      bmin_r <= bmin_nxt;
      bmax_r <= bmax_nxt;
    end
  end

  // stage E: strict interval test, touching ends do not count
  assign hit_nxt = (amin_r < bmax_r && amin_r > bmin_r)
                || (bmin_r < amax_r && bmin_r > amin_r)
                || (amin_r > bmin_r && amax_r < bmax_r)
                || (amin_r < bmin_r && amax_r > bmax_r);

  always_ff @(posedge clk) begin
    if (ctl.en_e) begin
      hit_r <= hit_nxt;
    end
  end

  assign hit = hit_r;

endmodule

// File: hw/rtl/obot_merge.sv
module obot_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          v_e,
  input  logic [obot_pkg::NUM_AXES-1:0] lane_hit,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_overlap,
  output logic                          o_free
);

  logic out_valid_r;
  logic overlap_r;

  assign o_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_free) begin
      out_valid_r <= v_e;
    end
  end

  // every axis must overlap
  always_ff @(posedge clk) begin
    if (o_free) begin
      overlap_r <= &lane_hit;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_overlap = overlap_r;

endmodule

// File: hw/rtl/oriented_box_overlap_test_unit.sv
// Box overlap unit: separating-axis test of a target box against a stored reference.
// Throughput: one word per cycle while the result side keeps up; load words give no result.
// Behind the input snapshot lie five stages (multiply, sum, min/max, compare, merge);
// the stall chain lets a new word in every cycle unless every stage is full and out_ready is low.
// Reset: synchronous active-low rst_n clears the pipeline and zeroes the reference box.
`include "oriented_box_overlap_test_unit_macros.svh"

module oriented_box_overlap_test_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic signed [obot_pkg::FIELD_W-1:0] in_corner0_x,
  input  logic signed [obot_pkg::FIELD_W-1:0] in_corner0_y,
  input  logic signed [obot_pkg::FIELD_W-1:0] in_corner1_x,
  input  logic signed [obot_pkg::FIELD_W-1:0] in_corner1_y,
  input  logic signed [obot_pkg::FIELD_W-1:0] in_corner2_x,
  input  logic signed [obot_pkg::FIELD_W-1:0] in_corner2_y,
  input  logic signed [obot_pkg::FIELD_W-1:0] in_corner3_x,
  input  logic signed [obot_pkg::FIELD_W-1:0] in_corner3_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_overlap
);

  localparam int CW = COORD_BITS;
  localparam int AW = COORD_BITS + 1;
  localparam int NC = obot_pkg::NUM_CRN;
  localparam int NP = obot_pkg::NUM_PTS;
  localparam int NA = obot_pkg::NUM_AXES;

  logic [obot_pkg::FIELD_W-1:0] fld_x [NC];
  logic [obot_pkg::FIELD_W-1:0] fld_y [NC];
  logic signed [CW-1:0]         crd_x [NC];
  logic signed [CW-1:0]         crd_y [NC];
  logic signed [CW-1:0]         ref_x_r [NC];
  logic signed [CW-1:0]         ref_y_r [NC];
  logic signed [CW-1:0]         pt_x_r [NP];
  logic signed [CW-1:0]         pt_y_r [NP];
  logic signed [AW-1:0]         ax_nxt [NA];
  logic signed [AW-1:0]         ay_nxt [NA];
  logic signed [AW-1:0]         ax_r [NA];
  logic signed [AW-1:0]         ay_r [NA];
  logic                         v_a_r, v_b_r, v_c_r, v_d_r, v_e_r;
  logic                         free_a, free_b, free_c, free_d, free_e, o_free;
  logic                         acc, acc_load, acc_test;
  logic [NA-1:0]                lane_hit;
  obot_pkg::ctl_t               ctl;

  assign fld_x[0] = in_corner0_x;
  assign fld_y[0] = in_corner0_y;
  assign fld_x[1] = in_corner1_x;
  assign fld_y[1] = in_corner1_y;
  assign fld_x[2] = in_corner2_x;
  assign fld_y[2] = in_corner2_y;
  assign fld_x[3] = in_corner3_x;
  assign fld_y[3] = in_corner3_y;

  // low COORD_BITS of each field, read as signed; wider coords see the field as unsigned
  for (genvar i = 0; i < NC; i++) begin : g_crd
    if (CW <= obot_pkg::FIELD_W) begin : g_narrow
      assign crd_x[i] = fld_x[i][CW-1:0];
      assign crd_y[i] = fld_y[i][CW-1:0];
    end else begin : g_wide
      assign crd_x[i] = CW'(fld_x[i]);
      assign crd_y[i] = CW'(fld_y[i]);
    end
  end

  // stall chain: a stage loads when empty or when its word moves on
  assign free_e   = !v_e_r || o_free;
  assign free_d   = !v_d_r || free_e;
  assign free_c   = !v_c_r || free_d;
  assign free_b   = !v_b_r || free_c;
  assign free_a   = !v_a_r || free_b;
  assign in_ready = free_a;

  assign ctl.en_b = free_b;
  assign ctl.en_c = free_c;
  assign ctl.en_d = free_d;
  assign ctl.en_e = free_e;

  assign acc      = in_valid && in_ready;
  assign acc_load = acc && (in_cmd == obot_pkg::CMD_LOAD);
  assign acc_test = acc && (in_cmd == obot_pkg::CMD_TEST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NC; k++) begin
        ref_x_r[k] <= '0;
        ref_y_r[k] <= '0;
      end
    end else if (acc_load) begin
      for (int k = 0; k < NC; k++) begin
        ref_x_r[k] <= crd_x[k];
        ref_y_r[k] <= crd_y[k];
      end
    end
  end

  // edge normals perp(c0 - c1) and perp(c0 - c3), perp(dx, dy) = (-dy, dx)
  always_comb begin
    ax_nxt[0] = AW'(ref_y_r[1]) - AW'(ref_y_r[0]);
    ay_nxt[0] = AW'(ref_x_r[0]) - AW'(ref_x_r[1]);
    ax_nxt[1] = AW'(ref_y_r[3]) - AW'(ref_y_r[0]);
    ay_nxt[1] = AW'(ref_x_r[0]) - AW'(ref_x_r[3]);
    ax_nxt[2] = AW'(crd_y[1]) - AW'(crd_y[0]);
    ay_nxt[2] = AW'(crd_x[0]) - AW'(crd_x[1]);
    ax_nxt[3] = AW'(crd_y[3]) - AW'(crd_y[0]);
    ay_nxt[3] = AW'(crd_x[0]) - AW'(crd_x[3]);
  end

  // stage A: snapshot of both boxes and the four axes
  always_ff @(posedge clk) begin
    if (free_a) begin
      for (int k = 0; k < NC; k++) begin
        pt_x_r[k]    <= ref_x_r[k];
        pt_y_r[k]    <= ref_y_r[k];
        pt_x_r[NC+k] <= crd_x[k];
        pt_y_r[NC+k] <= crd_y[k];
      end
      for (int j = 0; j < NA; j++) begin
        ax_r[j] <= ax_nxt[j];
        ay_r[j] <= ay_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
      v_e_r <= 1'b0;
    end else begin
      if (free_a) v_a_r <= acc_test;
      if (free_b) v_b_r <= v_a_r;
      if (free_c) v_c_r <= v_b_r;
      if (free_d) v_d_r <= v_c_r;
      if (free_e) v_e_r <= v_d_r;
    end
  end

  for (genvar j = 0; j < NA; j++) begin : g_lane
    obot_lane #(
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .axis_x (ax_r[j]),
      .axis_y (ay_r[j]),
      .pt_x   (pt_x_r),
      .pt_y   (pt_y_r),
      .hit    (lane_hit[j])
    );
  end

  obot_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .v_e         (v_e_r),
    .lane_hit    (lane_hit),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_overlap (out_overlap),
    .o_free      (o_free)
  );

  `OBOT_ASSERT_NEXT(a_load_updates_ref, clk, rst_n, acc_load, ref_x_r[0] == $past(crd_x[0]) && ref_y_r[3] == $past(crd_y[3]), "load word did not update reference")
  `OBOT_ASSERT_NEXT(a_test_enters_pipe, clk, rst_n, acc_test, v_a_r, "test word lost at pipeline entry")
  `OBOT_ASSERT_NEXT(a_load_no_result, clk, rst_n, acc_load, !v_a_r, "load word entered result pipeline")
  `OBOT_ASSERT_IMPLIES(a_full_stall, clk, rst_n, out_valid && !out_ready && v_a_r && v_b_r && v_c_r && v_d_r && v_e_r, !in_ready, "input taken while pipeline full and stalled")

endmodule

// File: sim/tb_oriented_box_overlap_test_unit.sv
module tb_oriented_box_overlap_test_unit;

  typedef logic [obot_pkg::NUM_PTS-1:0][obot_pkg::FIELD_W-1:0] pts_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = obot_pkg::CMD_LOAD;
  logic signed [obot_pkg::FIELD_W-1:0] in_corner0_x = '0;
  logic signed [obot_pkg::FIELD_W-1:0] in_corner0_y = '0;
  logic signed [obot_pkg::FIELD_W-1:0] in_corner1_x = '0;
  logic signed [obot_pkg::FIELD_W-1:0] in_corner1_y = '0;
  logic signed [obot_pkg::FIELD_W-1:0] in_corner2_x = '0;
  logic signed [obot_pkg::FIELD_W-1:0] in_corner2_y = '0;
  logic signed [obot_pkg::FIELD_W-1:0] in_corner3_x = '0;
  logic signed [obot_pkg::FIELD_W-1:0] in_corner3_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_overlap;

  // predictor state: the stored reference box, sign-extended
  longint ref_pts [obot_pkg::NUM_PTS];
  int     ref_cx = 0;
  int     ref_cy = 0;
  bit     overlap_q [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_len = 0;
  int n_errors = 0;
  int n_tests = 0;
  int n_loads = 0;
  int n_hits = 0;
  int n_in_stalls = 0;

  oriented_box_overlap_test_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .in_corner0_x(in_corner0_x),
    .in_corner0_y(in_corner0_y),
    .in_corner1_x(in_corner1_x),
    .in_corner1_y(in_corner1_y),
    .in_corner2_x(in_corner2_x),
    .in_corner2_y(in_corner2_y),
    .in_corner3_x(in_corner3_x),
    .in_corner3_y(in_corner3_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_overlap (out_overlap)
  );

  always begin
    #10;
    clk = 1'b1;
    #10;
    clk = 1'b0;
  end

  initial begin
    #8000000;
    $display("tb_oriented_box_overlap_test_unit: errors");
    $finish;
  end

  // ---------------- predictor ----------------

  function automatic bit axis_overlaps(input longint a [obot_pkg::NUM_PTS],
                                       input longint b [obot_pkg::NUM_PTS],
                                       input longint ax, input longint ay);
    longint amin, amax, bmin, bmax, d;
    amin = a[0] * ax + a[1] * ay;
    amax = amin;
    bmin = b[0] * ax + b[1] * ay;
    bmax = bmin;
    for (int k = 1; k < obot_pkg::NUM_CRN; k++) begin
      d = a[2*k] * ax + a[2*k+1] * ay;
      if (d < amin) amin = d;
      if (d > amax) amax = d;
      d = b[2*k] * ax + b[2*k+1] * ay;
      if (d < bmin) bmin = d;
      if (d > bmax) bmax = d;
    end
    // strict clauses: equal or touching intervals do not count
    return (amin < bmax && amin > bmin) || (bmin < amax && bmin > amin) ||
           (amin > bmin && amax < bmax) || (amin < bmin && amax > bmax);
  endfunction

  // edge normals of src, perp(c0 - c1) and perp(c0 - c3)
  function automatic bit normals_overlap(input longint src [obot_pkg::NUM_PTS],
                                         input longint a [obot_pkg::NUM_PTS],
                                         input longint b [obot_pkg::NUM_PTS]);
    longint e1x, e1y, e2x, e2y;
    e1x = src[0] - src[2];
    e1y = src[1] - src[3];
    e2x = src[0] - src[6];
    e2y = src[1] - src[7];
    return axis_overlaps(a, b, -e1y, e1x) && axis_overlaps(a, b, -e2y, e2x);
  endfunction

  function automatic bit boxes_overlap(input pts_t p);
    longint tgt [obot_pkg::NUM_PTS];
    for (int k = 0; k < obot_pkg::NUM_PTS; k++) tgt[k] = longint'($signed(p[k]));
    return normals_overlap(ref_pts, ref_pts, tgt) && normals_overlap(tgt, ref_pts, tgt);
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic int rand_offset(input int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  // rectangle from corner 0, edge (ex, ey) and the perpendicular edge scaled by s
  function automatic pts_t make_rect(input int cx, input int cy, input int ex, input int ey,
                                     input int s);
    pts_t r;
    r[0] = 16'(cx);
    r[1] = 16'(cy);
    r[2] = 16'(cx + ex);
    r[3] = 16'(cy + ey);
    r[4] = 16'(cx + ex - s * ey);
    r[5] = 16'(cy + ey + s * ex);
    r[6] = 16'(cx - s * ey);
    r[7] = 16'(cy + s * ex);
    return r;
  endfunction

  function automatic pts_t rand_rect(input int cx, input int cy, input int esz);
    return make_rect(cx, cy, rand_offset(esz), rand_offset(esz), $urandom_range(1, 3));
  endfunction

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_word(input obot_pkg::cmd_t c, input pts_t p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= c;
    in_corner0_x <= p[0];
    in_corner0_y <= p[1];
    in_corner1_x <= p[2];
    in_corner1_y <= p[3];
    in_corner2_x <= p[4];
    in_corner2_y <= p[5];
    in_corner3_x <= p[6];
    in_corner3_y <= p[7];
    @(posedge clk);
    while (!in_ready) begin
      n_in_stalls++;
      @(posedge clk);
    end
    if (c == obot_pkg::CMD_LOAD) begin
      for (int k = 0; k < obot_pkg::NUM_PTS; k++) ref_pts[k] = longint'($signed(p[k]));
      n_loads++;
    end else begin
      overlap_q.push_back(boxes_overlap(p));
      n_tests++;
    end
  endtask

  // ---------------- result side ----------------

  always @(posedge clk) begin
    if (stall_len > 0) begin
      out_ready <= 1'b0;
      stall_len <= stall_len - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    bit want_hit;
    if (rst_n && out_valid && out_ready) begin
      if (overlap_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result word: overlap=%0b", out_overlap);
      end else begin
        want_hit = overlap_q.pop_front();
        if (want_hit) n_hits++;
        if (out_overlap !== want_hit) begin
          n_errors++;
          if (n_errors <= 10)
            $display("overlap mismatch at %0t: expected %0b, got %0b", $time, want_hit,
                     out_overlap);
        end
      end
    end
  end

  // ---------------- tests ----------------

  task automatic test_directed();
    pts_t p;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // reference still the reset point
    send_word(obot_pkg::CMD_TEST, make_rect(0, 0, 100, 0, 1));
    send_word(obot_pkg::CMD_LOAD, make_rect(0, 0, 100, 0, 1));
    send_word(obot_pkg::CMD_TEST, make_rect(0, 0, 100, 0, 1));      // identical
    send_word(obot_pkg::CMD_TEST, make_rect(50, 50, 100, 0, 1));    // partial overlap
    send_word(obot_pkg::CMD_TEST, make_rect(100, 0, 100, 0, 1));    // edges touch
    send_word(obot_pkg::CMD_TEST, make_rect(0, 50, 100, 0, 1));     // same x span
    send_word(obot_pkg::CMD_TEST, make_rect(25, 25, 50, 0, 1));     // inside
    send_word(obot_pkg::CMD_TEST, make_rect(-50, -50, 200, 0, 1));  // around
    send_word(obot_pkg::CMD_TEST, make_rect(1000, 1000, 100, 0, 1));
    send_word(obot_pkg::CMD_TEST, make_rect(50, -20, 40, 40, 1));   // rotated
    send_word(obot_pkg::CMD_TEST, make_rect(140, -60, 40, 40, 1));  // rotated, clear of it
    send_word(obot_pkg::CMD_TEST, make_rect(50, 50, 0, 0, 1));      // degenerate point
    p = make_rect(20, 20, 30, 0, 2);
    p[2] = p[0];
    p[3] = p[1];
    send_word(obot_pkg::CMD_TEST, p);                                // one zero-length edge
    // full-range coordinates
    p[0] = 16'h8000; p[1] = 16'h8000;
    p[2] = 16'h7fff; p[3] = 16'h8000;
    p[4] = 16'h7fff; p[5] = 16'h7fff;
    p[6] = 16'h8000; p[7] = 16'h7fff;
    send_word(obot_pkg::CMD_TEST, p);
    send_word(obot_pkg::CMD_LOAD, p);
    send_word(obot_pkg::CMD_TEST, make_rect(32000, 32000, 700, 0, 1));
    send_word(obot_pkg::CMD_TEST, make_rect(-32768, -32768, 500, 0, 1));
    send_word(obot_pkg::CMD_TEST, p);
    send_word(obot_pkg::CMD_TEST, {$urandom, $urandom, $urandom, $urandom});
    send_word(obot_pkg::CMD_LOAD, make_rect(5, 5, 0, 0, 1));        // point reference
    send_word(obot_pkg::CMD_TEST, make_rect(-50, -50, 200, 0, 1));
    send_word(obot_pkg::CMD_LOAD, make_rect(0, 0, 300, 100, 2));
    ref_cx = 0;
    ref_cy = 0;
    send_word(obot_pkg::CMD_TEST, make_rect(100, 100, 50, -30, 1));
  endtask

  task automatic test_random(input int n_words, input int s_pct, input int r_pct);
    int            pick;
    pts_t          p;
    obot_pkg::cmd_t c;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n_words; i++) begin
      pick = $urandom_range(0, 99);
      c = obot_pkg::CMD_TEST;
      if (pick < 8) begin
        c = obot_pkg::cmd_t'($urandom_range(0, 1));
        p = {$urandom, $urandom, $urandom, $urandom};
      end else if (pick < 18) begin
        c = obot_pkg::CMD_LOAD;
        ref_cx = rand_offset(1500);
        ref_cy = rand_offset(1500);
        p = rand_rect(ref_cx, ref_cy, 400);
      end else if (pick < 22) begin
        p = rand_rect(ref_cx + rand_offset(400), ref_cy + rand_offset(400), 300);
        p[2] = p[0];
        p[3] = p[1];
      end else if (pick < 26) begin
        p = rand_rect(rand_offset(6000), rand_offset(6000), 3000);
      end else begin
        p = rand_rect(ref_cx + rand_offset(700), ref_cy + rand_offset(700), 400);
      end
      send_word(c, p);
    end
  endtask

  // result side holds off while test words keep coming, filling the pipeline
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_len = 400;
    for (int i = 0; i < 60; i++)
      send_word(obot_pkg::CMD_TEST,
                rand_rect(ref_cx + rand_offset(300), ref_cy + rand_offset(300), 250));
  endtask

  initial begin
    for (int k = 0; k < obot_pkg::NUM_PTS; k++) ref_pts[k] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(540, 28, 69);
    test_random(540, 69, 28);
    test_random(540, 0, 0);
    test_output_stall();
    in_valid <= 1'b0;
    for (int w = 0; w < 20000 && overlap_q.size() != 0; w++) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("covered %0d test words (%0d overlapping) against %0d reference loads,",
             n_tests, n_hits, n_loads);
    $display("with %0d cycles of input back-pressure seen", n_in_stalls);
    if (n_errors == 0 && overlap_q.size() == 0) begin
      $display("tb_oriented_box_overlap_test_unit: clean");
    end else begin
      $display("tb_oriented_box_overlap_test_unit: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/obot_pkg.sv
hw/rtl/obot_lane.sv
hw/rtl/obot_merge.sv
hw/rtl/oriented_box_overlap_test_unit.sv
sim/tb_oriented_box_overlap_test_unit.sv
